// File: hw/rtl/bfds_pkg.sv
// Shared types and constants for the bounded FIFO deadline server.
// Holds queue sizing, job and record layouts, state encoding and memory controls.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bfds_pkg;

  localparam int QUEUE_DEPTH = 3;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int TIME_W      = 32;

  localparam logic CMD_ARRIVE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  typedef enum logic [1:0] {
    OUTCOME_DONE   = 2'd0,
    OUTCOME_ABORT  = 2'd1,
    OUTCOME_REJECT = 2'd2
  } outcome_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] service;
    logic [TIME_W-1:0] deadline;
  } job_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    outcome_t          outcome;
    logic [TIME_W-1:0] event_time;
    logic [TIME_W-1:0] delay;
  } rec_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_START,
    ST_EVAL,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } qram_ctl_t;

endpackage

`default_nettype wire

// File: hw/rtl/bfds_if.sv
// Request channel interfaces for the bounded FIFO deadline server.
// Job input channel and result record channel; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface bfds_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [15:0] job_id;
  logic [31:0] arrival_time;
  logic [31:0] service_time;
  logic [31:0] deadline;

  modport source (output valid, command, job_id, arrival_time, service_time, deadline,
                  input ready);
  modport sink   (input valid, command, job_id, arrival_time, service_time, deadline,
                  output ready);
endinterface

interface bfds_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] done_id;
  logic [1:0]  outcome;
  logic [31:0] event_time;
  logic [31:0] wait_delay;
  logic        last_of_run;

  modport source (output valid, done_id, outcome, event_time, wait_delay, last_of_run,
                  input ready);
  modport sink   (input valid, done_id, outcome, event_time, wait_delay, last_of_run,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bounded_fifo_deadline_server.sv
// Bounded FIFO deadline server top level; uses bfds_pkg, bfds_if, bfds_qram, bfds_serve_calc.
// A job served at once passes the decide, start and evaluate states; drain loads its record.
// Per request: accept and decide, then read, evaluate and decide per queued job served,
// start and evaluate to serve the arriving job, and a closing record after a served or rejected
// arrival; a stalled result channel holds this, and a new request is taken only when idle.
// Reset: synchronous; clears queue pointers, free time and valid flags, not the job memory.
`timescale 1ns / 1ps
`default_nettype none

module bounded_fifo_deadline_server (
  input  logic              clk,
  input  logic              rst,
  bfds_in_if.sink           job,
  bfds_out_if.source        rec
);
  import bfds_pkg::*;

  state_t            state, state_next;
  logic              cmd;
  job_t              in_job;
  job_t              cur;
  logic [TIME_W-1:0] start;
  logic [TIME_W-1:0] free_time;
  logic [PTR_W-1:0]  head, tail;
  logic [CNT_W-1:0]  count;
  logic              from_queue;
  rec_t              pend;
  logic              pend_valid;
  rec_t              out_rec;
  logic              out_valid;
  logic              out_last;

  qram_ctl_t         qctl;
  job_t              qdata;
  job_t              job_src;
  rec_t              calc_rec;
  logic [TIME_W-1:0] calc_free;

  logic arr_ge, q_empty, q_full, more, out_free, decide_go;
  logic act_serve_q, act_serve_new, act_reject, act_enqueue;
  logic out_load, out_load_last, take_q, take_new, do_enq, do_reject, clear_free;
  logic job_ready, accept;

  bfds_qram u_qram (
    .clk   (clk),
    .ctl   (qctl),
    .wdata (in_job),
    .rdata (qdata)
  );

  bfds_serve_calc u_calc (
    .job       (cur),
    .start     (start),
    .rec       (calc_rec),
    .free_next (calc_free)
  );

  // decide what the current request does next
  always_comb begin
    arr_ge        = in_job.arrival >= free_time;
    q_empty       = count == '0;
    q_full        = count == CNT_W'(QUEUE_DEPTH);
    act_serve_q   = (cmd == CMD_FLUSH) ? !q_empty : (!q_empty && arr_ge);
    act_serve_new = (cmd == CMD_ARRIVE) && q_empty && arr_ge;
    act_reject    = (cmd == CMD_ARRIVE) && !act_serve_q && !act_serve_new && q_full;
    act_enqueue   = (cmd == CMD_ARRIVE) && !act_serve_q && !act_serve_new && !q_full;
    more          = act_serve_q || act_serve_new || act_reject;
    out_free      = !out_valid || rec.ready;
    decide_go     = !pend_valid || out_free;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (job.valid) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (decide_go) begin
          if (act_serve_q || act_serve_new) state_next = ST_START;
          else if (act_reject)               state_next = ST_DRAIN;
          else                               state_next = ST_IDLE;
        end
      end
      ST_START: state_next = ST_EVAL;
      ST_EVAL:  state_next = from_queue ? ST_DECIDE : ST_DRAIN;
      ST_DRAIN: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:  state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    qctl          = '0;
    qctl.rd_addr  = head;
    qctl.wr_addr  = tail;
    out_load      = 1'b0;
    out_load_last = 1'b0;
    take_q        = 1'b0;
    take_new      = 1'b0;
    do_enq        = 1'b0;
    do_reject     = 1'b0;
    clear_free    = 1'b0;
    job_ready     = 1'b0;
    case (state)
      ST_IDLE: job_ready = 1'b1;
      ST_DECIDE: begin
        if (decide_go) begin
          out_load      = pend_valid;
          out_load_last = !more;
          take_q        = act_serve_q;
          take_new      = act_serve_new;
          do_enq        = act_enqueue;
          do_reject     = act_reject;
          clear_free    = (cmd == CMD_FLUSH) && q_empty;
          qctl.rd_en    = act_serve_q;
          qctl.wr_en    = act_enqueue;
        end
      end
      ST_DRAIN: begin
        out_load      = out_free;
        out_load_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign accept    = job.valid && job_ready;
  assign job.ready = job_ready;
  assign job_src   = from_queue ? qdata : in_job;

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      free_time  <= '0;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      from_queue <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      // hold the output record until taken
      if (out_load)       out_valid <= 1'b1;
      else if (rec.ready) out_valid <= 1'b0;
      // pending record: drop on push, set on a new result
      if (out_load)                       pend_valid <= 1'b0;
      if (do_reject || state == ST_EVAL)  pend_valid <= 1'b1;
      // advance queue pointers
      if (take_q) begin
        head  <= (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
        count <= count - CNT_W'(1);
      end
      if (do_enq) begin
        tail  <= (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);
        count <= count + CNT_W'(1);
      end
      if (take_q)   from_queue <= 1'b1;
      if (take_new) from_queue <= 1'b0;
      // server free time
      if (clear_free)        free_time <= '0;
      if (state == ST_EVAL)  free_time <= calc_free;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd             <= job.command;
      in_job.id       <= job.job_id;
      in_job.arrival  <= job.arrival_time;
      in_job.service  <= job.service_time;
      in_job.deadline <= job.deadline;
    end
    if (state == ST_START) begin
      cur   <= job_src;
      start <= (free_time > job_src.arrival) ? free_time : job_src.arrival;
    end
    if (do_reject) begin
      pend.id         <= in_job.id;
      pend.outcome    <= OUTCOME_REJECT;
      pend.event_time <= in_job.arrival;
      pend.delay      <= '0;
    end
    if (state == ST_EVAL) pend <= calc_rec;
    if (out_load) begin
      out_rec  <= pend;
      out_last <= out_load_last;
    end
  end

  assign rec.valid       = out_valid;
  assign rec.done_id     = out_rec.id;
  assign rec.outcome     = out_rec.outcome;
  assign rec.event_time  = out_rec.event_time;
  assign rec.wait_delay  = out_rec.delay;
  assign rec.last_of_run = out_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_eval_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_EVAL |-> !pend_valid)
    else $error("pending record overwritten");

  a_read_nonempty: assert property (@(posedge clk) disable iff (rst)
    qctl.rd_en |-> count != '0)
    else $error("read from empty queue");

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rec.ready))
    else $error("output record overwritten");

  a_accept_clean: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_DECIDE && !pend_valid)
    else $error("request accepted with work in flight");

endmodule

`default_nettype wire

// File: hw/rtl/bfds_qram.sv
// Waiting-job memory: one write port, one read port, registered read data.
// Depends on bfds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfds_qram (
  input  logic                 clk,
  input  bfds_pkg::qram_ctl_t  ctl,
  input  bfds_pkg::job_t       wdata,
  output bfds_pkg::job_t       rdata
);
  import bfds_pkg::*;

  job_t mem [QUEUE_DEPTH];

  // write the tail entry
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= wdata;
    end
  end

  // read the head entry, registered
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[ctl.rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bfds_serve_calc.sv
// Service arithmetic for one job given its start tick.
// Picks completion or deadline abort and the new server free time. Depends on bfds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bfds_serve_calc (
  input  bfds_pkg::job_t                   job,
  input  logic [bfds_pkg::TIME_W-1:0]      start,
  output bfds_pkg::rec_t                   rec,
  output logic [bfds_pkg::TIME_W-1:0]      free_next
);
  import bfds_pkg::*;

  logic [TIME_W:0]   finish;
  logic [TIME_W-1:0] start_delay;
  logic [TIME_W-1:0] dl_delay;

  assign finish      = {1'b0, start} + {1'b0, job.service};
  assign start_delay = start - job.arrival;
  assign dl_delay    = job.deadline - job.arrival;

  // choose outcome: late start, overrun, or completion
  always_comb begin
    rec.id = job.id;
    if (start >= job.deadline) begin
      rec.outcome    = OUTCOME_ABORT;
      rec.event_time = start;
      rec.delay      = start_delay;
      free_next      = start;
    end else if (finish > {1'b0, job.deadline}) begin
      rec.outcome    = OUTCOME_ABORT;
      rec.event_time = job.deadline;
      rec.delay      = dl_delay;
      free_next      = job.deadline;
    end else begin
      rec.outcome    = OUTCOME_DONE;
      rec.event_time = finish[TIME_W-1:0];
      rec.delay      = start_delay;
      free_next      = finish[TIME_W-1:0];
    end
  end

endmodule

`default_nettype wire
